/* design/piecewise_linear_frame_map_top_macros.svh */
// Assertion macros for the piecewise-linear frame map.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef PIECEWISE_LINEAR_FRAME_MAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_FRAME_MAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PLFM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLFM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PLFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/plfm_pkg.sv */
// Shared types and constants for the piecewise-linear frame map.
// No dependencies.
package plfm_pkg;

    localparam int FRAME_BITS = 48;
    localparam int MAX_POINTS_DEFAULT = 1024;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_FORWARD = 2'd2;
    localparam logic [1:0] ACT_REVERSE = 2'd3;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [FRAME_BITS-1:0] point_source_frame;
        logic signed [FRAME_BITS-1:0] point_target_frame;
        logic signed [FRAME_BITS-1:0] query_frame;
    } req_t;

    typedef struct packed {
        logic signed [FRAME_BITS-1:0] mapped_frame;
        logic                         status;
    } rsp_t;

endpackage

/* design/piecewise_linear_frame_map_top.sv */
// Piecewise-linear frame map: point table, binary search and interpolation.
// Depends on plfm_pkg and piecewise_linear_frame_map_top_macros.svh.
//
// Usage: one request channel (req_valid/req_ready/req) and one response
// channel (rsp_valid/rsp_ready/rsp). Every request word gives exactly one
// response word. Clear and append answer the cycle after acceptance. A query
// on an empty table also answers in the cycle after acceptance. Other queries
// run a binary search over the key column (a read and a compare per probe, at
// most log2 of the point count plus one probes), the point reads ST_PT_RD and
// ST_PT_NX (a negative value answers zero, and a query not above its point's
// key or at the last point answers that value), then ST_DIFF_K, ST_DIFF_M,
// ST_DIFF_Q, a shift-add multiply and a restoring division on one shared
// adder, and ST_RND, ST_FIN and ST_DONE to round and finish. One request is
// in work at a time; req_ready is low meanwhile and also while a response
// waits in the output register with rsp_ready low. A stalled receiver holds
// the response register and thus the block. Reset empties the table (point
// count zero); column memories are not cleared and need no sweep.
module piecewise_linear_frame_map_top #(
    parameter int MAX_POINTS = plfm_pkg::MAX_POINTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  plfm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output plfm_pkg::rsp_t rsp
);
    import plfm_pkg::*;
    `include "piecewise_linear_frame_map_top_macros.svh"

    localparam int W      = FRAME_BITS;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int STEP_W = $clog2(W);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_SRCH_RD  = 13'b0000000000010,
        ST_SRCH_CMP = 13'b0000000000100,
        ST_PT_RD    = 13'b0000000001000,
        ST_PT_NX    = 13'b0000000010000,
        ST_DIFF_K   = 13'b0000000100000,
        ST_DIFF_M   = 13'b0000001000000,
        ST_DIFF_Q   = 13'b0000010000000,
        ST_MUL      = 13'b0000100000000,
        ST_DIV      = 13'b0001000000000,
        ST_RND      = 13'b0010000000000,
        ST_FIN      = 13'b0100000000000,
        ST_DONE     = 13'b1000000000000
    } state_t;

    logic [W-1:0] src_mem [MAX_POINTS];
    logic [W-1:0] tgt_mem [MAX_POINTS];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next, idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic rev_reg, rev_next;
    logic signed [W-1:0] q_reg, q_next;
    logic [W-1:0] last_src_reg, last_src_next, last_tgt_reg, last_tgt_next;
    logic [W-1:0] fk_reg, fk_next, fm_reg, fm_next;
    logic [W-1:0] dk_reg, dk_next, dm_reg, dm_next;
    logic [W-1:0] acc_reg, acc_next, lo_bits_reg, lo_bits_next;
    logic inc_reg, inc_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic [W-1:0] src_rd_reg, tgt_rd_reg;
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;

    // Shared adder/subtractor.
    logic [W:0]   alu_a, alu_b;
    logic         alu_sub, alu_cin;
    logic [W+1:0] alu_sum;

    logic [W-1:0] key_rd, val_rd;
    logic [CNT_W:0] mid_wide;
    logic [CNT_W-1:0] idx_plus;
    logic accept, out_free;

    assign alu_sum = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(W+2){alu_sub}})
                   + {{(W+1){1'b0}}, alu_cin};

    assign key_rd   = rev_reg ? tgt_rd_reg : src_rd_reg;
    assign val_rd   = rev_reg ? src_rd_reg : tgt_rd_reg;
    assign mid_wide = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_mem[count_reg[IDX_W-1:0]] <= req.point_source_frame;
            tgt_mem[count_reg[IDX_W-1:0]] <= req.point_target_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            src_rd_reg <= src_mem[rd_addr];
            tgt_rd_reg <= tgt_mem[rd_addr];
        end
    end

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        alu_cin = 1'b1;
        unique case (state_reg)
            ST_DIFF_K:
            begin
                alu_a = {1'b0, key_rd};
                alu_b = {1'b0, fk_reg};
            end
            ST_DIFF_M:
            begin
                alu_a = {1'b0, val_rd};
                alu_b = {1'b0, fm_reg};
            end
            ST_DIFF_Q:
            begin
                alu_a = {1'b0, q_reg};
                alu_b = {1'b0, fk_reg};
            end
            ST_MUL:
            begin
                alu_sub = 1'b0;
                alu_cin = 1'b0;
                alu_a   = {1'b0, acc_reg};
                alu_b   = lo_bits_reg[0] ? {1'b0, dm_reg} : '0;
            end
            ST_DIV:
            begin
                alu_a = {acc_reg, lo_bits_reg[W-1]};
                alu_b = {1'b0, dk_reg};
            end
            ST_RND:
            begin
                alu_a = {acc_reg, 1'b0};
                alu_b = {1'b0, dk_reg};
            end
            ST_FIN:
            begin
                alu_sub = 1'b0;
                alu_cin = inc_reg;
                alu_a   = {1'b0, fm_reg};
                alu_b   = {1'b0, lo_bits_reg};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        rev_next       = rev_reg;
        q_next         = q_reg;
        last_src_next  = last_src_reg;
        last_tgt_next  = last_tgt_reg;
        fk_next        = fk_reg;
        fm_next        = fm_reg;
        dk_next        = dk_reg;
        dm_next        = dm_reg;
        acc_next       = acc_reg;
        lo_bits_next   = lo_bits_reg;
        inc_next       = inc_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = mid_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.mapped_frame = '0;
                    rsp_next.status       = 1'b0;
                    rsp_valid_next        = 1'b1;
                    q_next   = req.query_frame;
                    rev_next = (req.action == ACT_REVERSE);
                    lo_next  = '0;
                    hi_next  = count_reg;
                    unique case (req.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else if (count_reg == '0 ||
                                     ($signed(req.point_source_frame) >
                                      $signed(last_src_reg) &&
                                      $signed(req.point_target_frame) >
                                      $signed(last_tgt_reg)))
                            begin
                                wr_en         = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                last_src_next = req.point_source_frame;
                                last_tgt_next = req.point_target_frame;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.mapped_frame = req.query_frame;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                state_next     = ST_SRCH_RD;
                            end
                        end
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_wide[IDX_W-1:0];
                    mid_next   = mid_wide[IDX_W-1:0];
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    idx_next   = (lo_reg == '0) ? '0 : IDX_W'(lo_reg - CNT_W'(1));
                    state_next = ST_PT_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                if ($signed(key_rd) <= q_reg)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = ST_SRCH_RD;
            end
            ST_PT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = ST_PT_NX;
            end
            ST_PT_NX:
            begin
                fk_next = key_rd;
                fm_next = val_rd;
                if (val_rd[W-1])
                begin
                    rsp_next.mapped_frame = '0;
                    state_next = ST_DONE;
                end
                else if (idx_plus < count_reg && q_reg > $signed(key_rd))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_plus[IDX_W-1:0];
                    state_next = ST_DIFF_K;
                end
                else
                begin
                    rsp_next.mapped_frame = val_rd;
                    state_next = ST_DONE;
                end
            end
            ST_DIFF_K:
            begin
                dk_next    = alu_sum[W-1:0];
                state_next = ST_DIFF_M;
            end
            ST_DIFF_M:
            begin
                dm_next    = alu_sum[W-1:0];
                state_next = ST_DIFF_Q;
            end
            ST_DIFF_Q:
            begin
                acc_next     = '0;
                lo_bits_next = alu_sum[W-1:0];
                step_next    = '0;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                // One shift-add step: the product builds up in acc and lo_bits.
                acc_next     = alu_sum[W:1];
                lo_bits_next = {alu_sum[0], lo_bits_reg[W-1:1]};
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring step; the remainder stays below dk, so W bits suffice.
                if (!alu_sum[W+1])
                begin
                    acc_next = alu_sum[W-1:0];
                end
                else
                begin
                    acc_next = {acc_reg[W-2:0], lo_bits_reg[W-1]};
                end
                lo_bits_next = {lo_bits_reg[W-2:0], !alu_sum[W+1]};
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(W - 1))
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                // Round up when twice the remainder exceeds dk, or ties to even.
                if (alu_sum[W+1])
                begin
                    inc_next = 1'b0;
                end
                else if (alu_sum[W:0] == '0)
                begin
                    inc_next = lo_bits_reg[0];
                end
                else
                begin
                    inc_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                rsp_next.mapped_frame = alu_sum[W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next.status = 1'b0;
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg      <= mid_next;
        idx_reg      <= idx_next;
        rev_reg      <= rev_next;
        q_reg        <= q_next;
        last_src_reg <= last_src_next;
        last_tgt_reg <= last_tgt_next;
        fk_reg       <= fk_next;
        fm_reg       <= fm_next;
        dk_reg       <= dk_next;
        dm_reg       <= dm_next;
        acc_reg      <= acc_next;
        lo_bits_reg  <= lo_bits_next;
        inc_reg      <= inc_next;
        rsp_reg      <= rsp_next;
    end

    `PLFM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
                     count_reg <= CNT_W'(MAX_POINTS))
    `PLFM_ASSERT_NOW(a_search_bounds, clk, rst_n, state_reg == ST_SRCH_RD,
                     lo_reg <= hi_reg && hi_reg <= count_reg)
    `PLFM_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, state_reg == ST_DIV,
                     acc_reg < dk_reg)
    `PLFM_ASSERT_NEXT(a_query_starts, clk, rst_n,
                      accept && req.action[1] && count_reg != '0,
                      state_reg == ST_SRCH_RD && !rsp_valid_reg)

endmodule

/* tb/sv/tb_piecewise_linear_frame_map_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for piecewise_linear_frame_map_top: table loads and queries
// in both directions, checked against a built-in table predictor.
// Depends on plfm_pkg and the RTL only.
module tb_piecewise_linear_frame_map_top;
    import plfm_pkg::*;

    localparam int TABLE_DEPTH = MAX_POINTS_DEFAULT;
    localparam int STALL_LIMIT = 5000;
    localparam int TARGET_WORDS = 1500;
    localparam logic signed [FRAME_BITS-1:0] F_MAX = {1'b0, {(FRAME_BITS-1){1'b1}}};
    localparam logic signed [FRAME_BITS-1:0] F_MIN = {1'b1, {(FRAME_BITS-1){1'b0}}};
    localparam longint L_MAX = 64'sh0000_7FFF_FFFF_FFFF;

    typedef struct {
        req_t word;
        bit   drain_first;
    } pending_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    pending_t pending_words[$];
    rsp_t     expected_rsp[$];

    // Predictor state: its own copy of the point table.
    logic signed [FRAME_BITS-1:0] src_col [TABLE_DEPTH];
    logic signed [FRAME_BITS-1:0] tgt_col [TABLE_DEPTH];
    int point_total;

    int  mismatches;
    int  send_gap;
    int  recv_gap;
    int  recv_words;
    int  holdoff_left;
    bit  holdoff_done;
    bit  calm;
    int  idle_cycles;
    int  n_sent;
    int  n_queries;
    int  n_full_drops;

    piecewise_linear_frame_map_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Mostly short gaps, a few long ones, and stretches with none at all.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 299) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [FRAME_BITS-1:0] key_at(bit reverse, int i);
        return reverse ? tgt_col[i] : src_col[i];
    endfunction

    function automatic logic signed [FRAME_BITS-1:0] val_at(bit reverse, int i);
        return reverse ? src_col[i] : tgt_col[i];
    endfunction

    // Maps a frame through the table with exact interpolation, round half to even.
    function automatic logic [FRAME_BITS-1:0] map_through(bit reverse,
                                                        logic signed [FRAME_BITS-1:0] q);
        int lo;
        int hi;
        int mid;
        int idx;
        longint fk;
        longint fm;
        longint q64;
        logic [63:0] dk;
        logic [63:0] dm;
        logic [63:0] dq;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [63:0] sum;
        lo = 0;
        hi = point_total;
        if (point_total == 0)
            return q;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_at(reverse, mid) <= q)
                lo = mid + 1;
            else
                hi = mid;
        end
        idx = (lo != 0) ? lo - 1 : 0;
        fk = longint'(key_at(reverse, idx));
        fm = longint'(val_at(reverse, idx));
        q64 = longint'(q);
        if (fm < 0)
            return '0;
        if (idx + 1 < point_total && q64 > fk)
        begin
            dk = longint'(key_at(reverse, idx + 1)) - fk;
            dm = longint'(val_at(reverse, idx + 1)) - fm;
            dq = q64 - fk;
            if (dk != 0 && dq < dk)
            begin
                prod = {64'd0, dm} * {64'd0, dq};
                quo = prod / {64'd0, dk};
                rem = prod % {64'd0, dk};
                if (rem[63:0] > dk - rem[63:0] ||
                    (rem[63:0] == dk - rem[63:0] && quo[0]))
                    quo = quo + 128'd1;
                sum = fm + quo[63:0];
                return sum[FRAME_BITS-1:0];
            end
        end
        return fm[FRAME_BITS-1:0];
    endfunction

    function automatic rsp_t predict_word(req_t w);
        rsp_t r;
        r = '0;
        case (w.action)
            ACT_CLEAR:
                point_total = 0;
            ACT_APPEND:
                if (point_total >= TABLE_DEPTH)
                    r.status = 1'b1;
                else if (point_total == 0 ||
                         (w.point_source_frame > src_col[point_total-1] &&
                          w.point_target_frame > tgt_col[point_total-1]))
                begin
                    src_col[point_total] = w.point_source_frame;
                    tgt_col[point_total] = w.point_target_frame;
                    point_total++;
                end
            ACT_FORWARD:
                r.mapped_frame = map_through(1'b0, w.query_frame);
            default:
                r.mapped_frame = map_through(1'b1, w.query_frame);
        endcase
        return r;
    endfunction

    // Sender: presents queued words, with gaps and drain points.
    always @(posedge clk or negedge rst_n)
    begin
        pending_t next_word;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
            point_total = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp.push_back(predict_word(req));
                n_sent++;
                if (req.action == ACT_FORWARD || req.action == ACT_REVERSE)
                    n_queries++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && expected_rsp.size() != 0))
                begin
                    next_word = pending_words.pop_front();
                    req       <= next_word.word;
                    req_valid <= 1'b1;
                    send_gap  <= pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that backs the block up.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_word;
        if (!rst_n)
        begin
            rsp_ready    <= 1'b0;
            recv_gap     <= 0;
            holdoff_left <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                recv_words++;
                if (rsp.status)
                    n_full_drops++;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response word mapped=%0d status=%0b",
                                 $realtime, rsp.mapped_frame, rsp.status);
                end
                else
                begin
                    exp_word = expected_rsp.pop_front();
                    if (exp_word.mapped_frame != rsp.mapped_frame ||
                        exp_word.status != rsp.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected mapped=%0d status=%0b,",
                                      " got mapped=%0d status=%0b"},
                                     $realtime, exp_word.mapped_frame, exp_word.status,
                                     rsp.mapped_frame, rsp.status);
                    end
                end
            end
            if (!holdoff_done && recv_words == 200)
            begin
                holdoff_done = 1'b1;
                holdoff_left <= 600;
                rsp_ready    <= 1'b0;
            end
            else if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                rsp_ready    <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (rsp_valid && rsp_ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("tb_piecewise_linear_frame_map_top: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int     queued;
    longint gen_src[$];
    longint gen_tgt[$];

    task automatic queue_word(logic [1:0] act, longint s, longint t, longint q, bit drain);
        pending_t p;
        p.word.action             = act;
        p.word.point_source_frame = s[FRAME_BITS-1:0];
        p.word.point_target_frame = t[FRAME_BITS-1:0];
        p.word.query_frame        = q[FRAME_BITS-1:0];
        p.drain_first             = drain;
        pending_words.push_back(p);
        queued++;
    endtask

    function automatic longint rand_frame();
        logic signed [FRAME_BITS-1:0] v;
        v = FRAME_BITS'({$urandom, $urandom});
        return longint'(v);
    endfunction

    function automatic longint rand_step(int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return longint'(v & ((64'd1 << bits) - 1)) + 1;
    endfunction

    // Appends a strictly increasing run of points; unless dense, some broken ones are mixed in.
    task automatic load_points(int npts, bit dense);
        longint s;
        longint t;
        int bits;
        bits = $urandom_range(2, 44);
        s = dense ? 0 : rand_frame();
        t = dense ? 0 : rand_frame();
        if ($urandom_range(0, 3) == 0)
            t = -rand_step(bits);
        for (int i = 0; i < npts; i++)
        begin
            if (!dense && $urandom_range(0, 9) == 0)
                queue_word(ACT_APPEND, rand_frame(), rand_frame(), rand_frame(), 1'b0);
            else
            begin
                if (s > L_MAX || t > L_MAX)
                    break;
                queue_word(ACT_APPEND, s, t, rand_frame(), 1'b0);
                gen_src.push_back(s);
                gen_tgt.push_back(t);
                s = s + (dense ? rand_step(10) : rand_step(bits));
                t = t + (dense ? rand_step(10) : rand_step($urandom_range(2, 44)));
            end
        end
    endtask

    task automatic run_queries(int nq, bit drain_first);
        longint keys[$];
        longint q;
        int k;
        bit reverse;
        for (int i = 0; i < nq; i++)
        begin
            reverse = 1'($urandom_range(0, 1));
            if (reverse)
                keys = gen_tgt;
            else
                keys = gen_src;
            k = $urandom_range(0, 9);
            if (keys.size() == 0 || k >= 8)
                q = rand_frame();
            else if (k >= 7)
                q = $urandom_range(0, 1) ? F_MAX : F_MIN;
            else if (k >= 4)
                q = keys[$urandom_range(0, keys.size() - 1)] + $signed($urandom_range(0, 6)) - 3;
            else
            begin
                q = keys[$urandom_range(0, keys.size() - 1)];
                q = q + rand_step($urandom_range(1, 44));
                if (q > L_MAX)
                    q = L_MAX;
            end
            queue_word(reverse ? ACT_REVERSE : ACT_FORWARD, rand_frame(), rand_frame(), q,
                       drain_first && i == 0);
        end
    endtask

    initial
    begin
        int episode;
        int npts;
        calm         = 1'b0;
        holdoff_done = 1'b0;
        mismatches   = 0;
        recv_words   = 0;
        idle_cycles  = 0;
        queued       = 0;
        n_sent       = 0;
        n_queries    = 0;
        n_full_drops = 0;

        // Directed: empty table, negative values, drops, clamps and the full frame range.
        queue_word(ACT_FORWARD, 0, 0, F_MAX, 1'b0);
        queue_word(ACT_REVERSE, 0, 0, F_MIN, 1'b0);
        queue_word(ACT_APPEND, -1000, -500, 0, 1'b0);
        queue_word(ACT_APPEND, 1000, 1500, 0, 1'b0);
        queue_word(ACT_APPEND, -5, 2000, 0, 1'b0);
        queue_word(ACT_APPEND, 2000, 1400, 0, 1'b0);
        queue_word(ACT_APPEND, 3000, F_MAX, 0, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, F_MIN, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, 0, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, 1500, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, 1001, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, F_MAX, 1'b0);
        queue_word(ACT_REVERSE, 0, 0, 1000, 1'b0);
        queue_word(ACT_REVERSE, 0, 0, F_MAX - 1, 1'b0);
        queue_word(ACT_CLEAR, F_MAX, F_MIN, -1, 1'b0);
        queue_word(ACT_APPEND, F_MIN, 0, 0, 1'b0);
        queue_word(ACT_APPEND, F_MAX, F_MAX, 0, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, 0, 1'b0);
        queue_word(ACT_FORWARD, 0, 0, 7, 1'b0);
        queue_word(ACT_REVERSE, 0, 0, 12345, 1'b0);
        queue_word(ACT_REVERSE, 0, 0, F_MIN, 1'b0);
        queue_word(ACT_CLEAR, 0, 0, 0, 1'b0);

        episode = 0;
        while (queued < TARGET_WORDS)
        begin
            // Occasionally skip the clear so appends land on an old table.
            if ($urandom_range(0, 9) != 0)
            begin
                queue_word(ACT_CLEAR, rand_frame(), rand_frame(), rand_frame(), 1'b0);
                gen_src.delete();
                gen_tgt.delete();
            end
            if (episode == 3)
            begin
                gen_src.delete();
                gen_tgt.delete();
                load_points(TABLE_DEPTH + 6, 1'b1);
            end
            else
            begin
                npts = $urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
                load_points(npts, 1'b0);
            end
            run_queries($urandom_range(4, 20), episode == 5 || $urandom_range(0, 49) == 0);
            if ($urandom_range(0, 4) == 0)
                queue_word(2'($urandom_range(0, 3)), rand_frame(), rand_frame(),
                           rand_frame(), 1'b0);
            episode++;
        end

        wait (rst_n);
        while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d words (%0d queries) over %0d table loads;",
                 n_sent, n_queries, episode);
        $display("%0d appends hit a full table, with one long receiver hold-off.",
                 n_full_drops);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("tb_piecewise_linear_frame_map_top: clean");
        else
            $display("tb_piecewise_linear_frame_map_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/plfm_pkg.sv
design/piecewise_linear_frame_map_top.sv
tb/sv/tb_piecewise_linear_frame_map_top.sv
